@@ sv/mcid_pkg.sv @@
package mcid_pkg;

	localparam int CHANNELS    = 12;
	localparam int PERIOD_BITS = 16;
	localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;
	localparam int APP_W       = 12;

	// input item modes
	typedef enum logic [1:0] {
		MODE_LEVEL  = 2'd0,
		MODE_TICK   = 2'd1,
		MODE_INIT   = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	// register indexes (byte address / 8)
	typedef enum logic [2:0] {
		REG_HOLD_LOW  = 3'd0,
		REG_HOLD_MID  = 3'd1,
		REG_HOLD_HIGH = 3'd2,
		REG_VAL_HIGH  = 3'd3,
		REG_VAL_LOW   = 3'd4,
		REG_ACTIVE    = 3'd5,
		REG_SPARE6    = 3'd6,
		REG_SPARE7    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] channel;
		logic       level;
	} item_t;

	typedef struct packed {
		logic [3:0] report_channel;
		logic       report_state;
		logic       last;
	} rpt_t;

	typedef struct packed {
		logic [2:0][63:0]  hold;
		logic [APP_W-1:0]  val_high;
		logic [APP_W-1:0]  val_low;
		logic [APP_W-1:0]  active;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic                accept;
		logic                step;
		logic                flush;
		logic                idle;
		logic [CH_IDX_W-1:0] idx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic commit_hit;
		logic pend_valid;
		logic out_free;
	} sts_t;

	// hold period of one channel, four 16-bit slots per register
	function automatic logic [PERIOD_BITS-1:0] hold_of(cfg_t cfg, logic [3:0] ch);
		logic [63:0] r;
		logic [1:0]  grp;
		logic [1:0]  slot;
		grp  = ch[3:2];
		slot = ch[1:0];
		case (grp)
			2'd0:    r = cfg.hold[0];
			2'd1:    r = cfg.hold[1];
			default: r = cfg.hold[2];
		endcase
		return r[{slot, 4'b0000} +: PERIOD_BITS];
	endfunction

endpackage

@@ sv/mcid_regs.sv @@
module mcid_regs import mcid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [2:0][63:0] hold_q;
	logic [APP_W-1:0] val_high_q;
	logic [APP_W-1:0] val_low_q;
	logic [APP_W-1:0] active_q;
	reg_idx_t         idx;
	logic             wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[5:3]);
	assign wr     = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q     <= '0;
			val_high_q <= '1;
			val_low_q  <= '0;
			active_q   <= '1;
		end else if (wr) begin
			case (idx)
				REG_HOLD_LOW:  hold_q[0]  <= pwdata;
				REG_HOLD_MID:  hold_q[1]  <= pwdata;
				REG_HOLD_HIGH: hold_q[2]  <= pwdata;
				REG_VAL_HIGH:  val_high_q <= pwdata[APP_W-1:0];
				REG_VAL_LOW:   val_low_q  <= pwdata[APP_W-1:0];
				REG_ACTIVE:    active_q   <= pwdata[APP_W-1:0];
				default:       ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_HOLD_LOW:  prdata = hold_q[0];
			REG_HOLD_MID:  prdata = hold_q[1];
			REG_HOLD_HIGH: prdata = hold_q[2];
			REG_VAL_HIGH:  prdata = {{(DATA_W-APP_W){1'b0}}, val_high_q};
			REG_VAL_LOW:   prdata = {{(DATA_W-APP_W){1'b0}}, val_low_q};
			REG_ACTIVE:    prdata = {{(DATA_W-APP_W){1'b0}}, active_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg.hold     = hold_q;
	assign cfg.val_high = val_high_q;
	assign cfg.val_low  = val_low_q;
	assign cfg.active   = active_q;

endmodule

@@ sv/mcid_ctrl.sv @@
module mcid_ctrl import mcid_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic is_tick,
	output logic item_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(CHANNELS - 1);

	state_t              state_q;
	logic [CH_IDX_W-1:0] idx_q;
	logic                accept;
	logic                go;
	logic                step;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid & (state_q == ST_IDLE);
	// a commit must push the held report out, which needs a free output slot
	assign go         = !(sts.commit_hit && sts.pend_valid && !sts.out_free);
	assign step       = (state_q == ST_SCAN) & go;

	// sequencer over the channels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && is_tick) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (go) begin
						if (idx_q == LAST_CH) begin
							state_q <= ST_FLUSH;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (!sts.pend_valid || sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					idx_q   <= '0;
				end
			endcase
		end
	end

	assign cmd.accept = accept;
	assign cmd.step   = step;
	assign cmd.flush  = (state_q == ST_FLUSH);
	assign cmd.idle   = (state_q == ST_IDLE);
	assign cmd.idx    = idx_q;

`ifndef NO_ASSERTIONS
	a_last_to_flush: assert property (@(posedge clk) disable iff (!arst_n)
		step && idx_q == LAST_CH |=> state_q == ST_FLUSH)
		else $error("scan of last channel did not enter flush");
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> idx_q == '0)
		else $error("channel index not cleared while idle");
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_tick |=> state_q == ST_SCAN && idx_q == '0)
		else $error("tick did not start a scan at channel zero");
`endif

endmodule

@@ sv/mcid_dp.sv @@
module mcid_dp import mcid_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  item_t item,
	input  cmd_t  cmd,
	output sts_t  sts,
	output logic  rpt_valid,
	input  logic  rpt_stall,
	output rpt_t  rpt
);

	logic [CHANNELS-1:0]    comm_q;
	logic [CHANNELS-1:0]    samp_q;
	logic [CHANNELS-1:0]    armed_q;
	logic [PERIOD_BITS-1:0] rem_q [CHANNELS];

	logic                pend_valid_q;
	logic [3:0]          pend_ch_q;
	logic                pend_state_q;
	logic                rpt_valid_q;
	rpt_t                rpt_q;

	logic                in_range;
	logic [CH_IDX_W-1:0] chi;
	logic                map_s;
	logic                act_s;
	logic                s_i;
	logic                c_i;
	logic [PERIOD_BITS-1:0] rem_eff;
	logic                commit_hit;
	logic                out_free;
	mode_t               mode;

	// input transaction decode
	assign mode     = mode_t'(item.mode);
	assign in_range = ({1'b0, item.channel} < 5'(CHANNELS));
	assign chi      = item.channel[CH_IDX_W-1:0];
	assign map_s    = item.level ? cfg.val_high[chi] : cfg.val_low[chi];
	assign act_s    = cfg.active[chi];

	// scanned channel
	assign s_i        = samp_q[cmd.idx];
	assign c_i        = comm_q[cmd.idx];
	assign rem_eff    = armed_q[cmd.idx] ? rem_q[cmd.idx] : hold_of(cfg, 4'(cmd.idx));
	assign commit_hit = (s_i != c_i) && (rem_eff == '0);
	assign out_free   = !rpt_valid_q || !rpt_stall;

	// channel state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comm_q  <= '0;
			samp_q  <= '0;
			armed_q <= '0;
			for (int i = 0; i < CHANNELS; i++) rem_q[i] <= '0;
		end else if (cmd.accept && in_range && mode == MODE_LEVEL) begin
			samp_q[chi] <= map_s;
		end else if (cmd.accept && in_range && mode == MODE_INIT) begin
			samp_q[chi]  <= map_s;
			comm_q[chi]  <= (map_s == act_s) ? ~map_s : map_s;
			armed_q[chi] <= 1'b0;
			rem_q[chi]   <= '0;
		end else if (cmd.step) begin
			if (s_i == c_i) begin
				armed_q[cmd.idx] <= 1'b0;
			end else if (rem_eff == '0) begin
				armed_q[cmd.idx] <= 1'b0;
				comm_q[cmd.idx]  <= s_i;
				rem_q[cmd.idx]   <= '0;
			end else begin
				armed_q[cmd.idx] <= 1'b1;
				rem_q[cmd.idx]   <= rem_eff - 1'b1;
			end
		end
	end

	// held report and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			rpt_valid_q  <= 1'b0;
		end else begin
			if (cmd.step && commit_hit) begin
				// a held report moves out, otherwise the output keeps or drains its own
				rpt_valid_q  <= pend_valid_q | (rpt_valid_q & rpt_stall);
				pend_valid_q <= 1'b1;
			end else if (cmd.flush && pend_valid_q && out_free) begin
				rpt_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (!rpt_stall) begin
				rpt_valid_q <= 1'b0;
			end
		end
	end

	// report payload, last is set only when the tick's scan is done
	always_ff @(posedge clk) begin
		if (cmd.step && commit_hit) begin
			if (pend_valid_q) begin
				rpt_q.report_channel <= pend_ch_q;
				rpt_q.report_state   <= pend_state_q;
				rpt_q.last           <= 1'b0;
			end
			pend_ch_q    <= 4'(cmd.idx);
			pend_state_q <= s_i;
		end
		if (cmd.flush && pend_valid_q && out_free) begin
			rpt_q.report_channel <= pend_ch_q;
			rpt_q.report_state   <= pend_state_q;
			rpt_q.last           <= 1'b1;
		end
	end

	assign rpt_valid      = rpt_valid_q;
	assign rpt            = rpt_q;
	assign sts.commit_hit = commit_hit;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;

`ifndef NO_ASSERTIONS
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && commit_hit && pend_valid_q |-> out_free)
		else $error("commit pushed a report into a full output register");
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.idle |-> !pend_valid_q)
		else $error("report still held while idle");
	a_commit_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && commit_hit |=> pend_valid_q)
		else $error("commit did not leave a held report");
`endif

endmodule

@@ sv/multi_channel_input_debouncer.sv @@
// channel   handshake                        payload
// item      item_valid / item_stall          item_t: mode, channel, level
// rpt       rpt_valid / rpt_stall            rpt_t: report_channel, report_state, last
// config    psel penable pwrite pready       paddr (8*index), pwdata / prdata 64 bits
//
// level events and initial samples are taken while idle; the item port stays free for the next item
// a tick scans all CHANNELS (12) channels and then flushes, one channel per cycle unless the scan is held,
//   through the single shared countdown/compare path in the datapath
// a stalled report output holds the scan when a second commit needs the output register
// arst_n clears all channel state and the valid flags of the held report and the output register
module multi_channel_input_debouncer import mcid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              rpt_valid,
	input  logic              rpt_stall,
	output rpt_t              rpt,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;
	logic is_tick;

	assign is_tick = (mode_t'(item.mode) == MODE_TICK);

	// configuration registers
	mcid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// scan controller
	mcid_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.is_tick    (is_tick),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// channel state and report datapath
	mcid_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.rpt_valid (rpt_valid),
		.rpt_stall (rpt_stall),
		.rpt       (rpt)
	);

endmodule

@@ tb/debounce_checker.sv @@
module debounce_checker import mcid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  item_t             item,
	input  logic              rpt_valid,
	input  logic              rpt_stall,
	input  rpt_t              rpt,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	output int                failures,
	output int                pending,
	output int                reports_checked
);

	localparam int MAX_PRINTED = 50;

	// shadow copy of the register file
	logic [63:0]      hold_cfg [3];
	logic [APP_W-1:0] map_high;
	logic [APP_W-1:0] map_low;
	logic [APP_W-1:0] active_mask;

	// per-channel debounce state
	logic [CHANNELS-1:0]    committed;
	logic [CHANNELS-1:0]    sampled;
	logic [CHANNELS-1:0]    armed;
	logic [PERIOD_BITS-1:0] countdown [CHANNELS];

	rpt_t expected_reports [$];
	rpt_t want;
	int   c_rst;

	task automatic note_mismatch(input string msg);
		if (failures < MAX_PRINTED)
			$display("mismatch at %0t: %s", $time, msg);
		failures++;
	endtask

	function automatic logic [PERIOD_BITS-1:0] hold_period(input int c);
		return hold_cfg[c / 4][16 * (c % 4) +: PERIOD_BITS];
	endfunction

	function automatic logic pin_to_app(input int c, input logic lvl);
		return lvl ? map_high[c] : map_low[c];
	endfunction

	// advance the debouncer by one transaction and queue the reports it commits
	task automatic debounce_item(input item_t it);
		int   c;
		int   k;
		logic s;
		rpt_t hit;
		rpt_t commits [$];
		case (it.mode)
			MODE_LEVEL: begin
				if (it.channel < CHANNELS)
					sampled[it.channel] = pin_to_app(int'(it.channel), it.level);
			end
			MODE_INIT: begin
				if (it.channel < CHANNELS) begin
					s = pin_to_app(int'(it.channel), it.level);
					sampled[it.channel]   = s;
					// an input already active at start-up is reported once its hold period expires
					committed[it.channel] = s ^ (s == active_mask[it.channel]);
					armed[it.channel]     = 1'b0;
					countdown[it.channel] = '0;
				end
			end
			MODE_TICK: begin
				for (c = 0; c < CHANNELS; c++) begin
					if (committed[c] == sampled[c]) begin
						armed[c] = 1'b0;
					end else begin
						if (!armed[c]) begin
							countdown[c] = hold_period(c);
							armed[c]     = 1'b1;
						end
						if (countdown[c] == 0) begin
							armed[c]     = 1'b0;
							committed[c] = sampled[c];
							hit.report_channel = 4'(c);
							hit.report_state   = sampled[c];
							hit.last           = 1'b0;
							commits.push_back(hit);
						end else begin
							countdown[c] = countdown[c] - 1'b1;
						end
					end
				end
				// last flag marks the final report of this tick
				for (k = 0; k < commits.size(); k++) begin
					hit      = commits[k];
					hit.last = (k == commits.size() - 1);
					expected_reports.push_back(hit);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cfg[0] = '0;
			hold_cfg[1] = '0;
			hold_cfg[2] = '0;
			map_high    = '1;
			map_low     = '0;
			active_mask = '1;
			committed   = '0;
			sampled     = '0;
			armed       = '0;
			for (c_rst = 0; c_rst < CHANNELS; c_rst++)
				countdown[c_rst] = '0;
			expected_reports.delete();
			failures = 0;
			reports_checked <= 0;
			pending <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:3])
					REG_HOLD_LOW:  hold_cfg[0] = pwdata;
					REG_HOLD_MID:  hold_cfg[1] = pwdata;
					REG_HOLD_HIGH: hold_cfg[2] = pwdata;
					REG_VAL_HIGH:  map_high    = pwdata[APP_W-1:0];
					REG_VAL_LOW:   map_low     = pwdata[APP_W-1:0];
					REG_ACTIVE:    active_mask = pwdata[APP_W-1:0];
					default: ;
				endcase
			end
			// input transaction
			if (item_valid && !item_stall)
				debounce_item(item);
			// report transaction
			if (rpt_valid && !rpt_stall) begin
				if (expected_reports.size() == 0) begin
					note_mismatch($sformatf("unexpected report, channel %0d state %0d last %0d",
						rpt.report_channel, rpt.report_state, rpt.last));
				end else begin
					want = expected_reports.pop_front();
					if (rpt.report_channel !== want.report_channel)
						note_mismatch($sformatf("report_channel expected %0d got %0d",
							want.report_channel, rpt.report_channel));
					if (rpt.report_state !== want.report_state)
						note_mismatch($sformatf("report_state of channel %0d expected %0d got %0d",
							want.report_channel, want.report_state, rpt.report_state));
					if (rpt.last !== want.last)
						note_mismatch($sformatf("last of channel %0d expected %0d got %0d",
							want.report_channel, want.last, rpt.last));
				end
				reports_checked <= reports_checked + 1;
			end
			pending <= expected_reports.size();
		end
	end

endmodule

@@ tb/tb.sv @@
module tb;
	import mcid_pkg::*;

	localparam int LIMIT  = 400000;
	localparam int SETTLE = 20;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	item_t             item;
	logic              rpt_valid;
	logic              rpt_stall;
	rpt_t              rpt;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int failures;
	int pending;
	int reports_checked;

	int          cycles = 0;
	int          items_sent = 0;
	int          settings_used = 0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	int unsigned rx_hold;
	int unsigned rx_draw;

	multi_channel_input_debouncer dut (.*);

	debounce_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.item            (item),
		.rpt_valid       (rpt_valid),
		.rpt_stall       (rpt_stall),
		.rpt             (rpt),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.failures        (failures),
		.pending         (pending),
		.reports_checked (reports_checked)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// report side: random stall per transaction, with calm stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			rpt_stall <= 1'b0;
			rx_hold   <= 0;
		end else if (rpt_valid && !rpt_stall) begin
			if ($urandom_range(0, 29) == 0)
				rx_calm = !rx_calm;
			rx_draw = rx_calm ? 0 : $urandom_range(0, 5);
			rx_hold   <= rx_draw;
			rpt_stall <= (rx_draw != 0);
		end else if (rpt_valid && rx_hold != 0) begin
			rx_hold   <= rx_hold - 1;
			rpt_stall <= (rx_hold > 1);
		end
	end

	task automatic send_item(input logic [1:0] mode, input logic [3:0] ch, input logic lvl);
		int unsigned gap;
		if ($urandom_range(0, 29) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.mode    <= mode;
		item.channel <= ch;
		item.level   <= lvl;
		item_valid   <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [63:0] h_lo, input logic [63:0] h_mid,
		input logic [63:0] h_hi, input logic [63:0] v_hi, input logic [63:0] v_lo,
		input logic [63:0] act);
		write_reg(REG_HOLD_LOW, h_lo);
		write_reg(REG_HOLD_MID, h_mid);
		write_reg(REG_HOLD_HIGH, h_hi);
		write_reg(REG_VAL_HIGH, v_hi);
		write_reg(REG_VAL_LOW, v_lo);
		write_reg(REG_ACTIVE, act);
		settings_used++;
	endtask

	// stop sending until every expected report is back, then let a tick finish
	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [63:0] periods_upto(input int maxp);
		logic [63:0] v;
		int          j;
		v = '0;
		for (j = 0; j < 4; j++)
			v[16 * j +: 16] = 16'($urandom_range(0, maxp));
		return v;
	endfunction

	// mostly bounce-then-tick sequences, the rest loose random transactions
	task automatic run_phase(input int count);
		int          sent;
		int          k;
		int unsigned r;
		logic [3:0]  ch;
		logic [1:0]  mode;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 60) begin
				ch = 4'($urandom_range(0, CHANNELS - 1));
				k  = $urandom_range(1, 4);
				repeat (k) begin
					send_item(MODE_LEVEL, ch, 1'($urandom_range(0, 1)));
					sent++;
				end
				k = $urandom_range(1, 5);
				repeat (k) begin
					send_item(MODE_TICK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
					sent++;
				end
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40)
					mode = MODE_LEVEL;
				else if (r < 78)
					mode = MODE_TICK;
				else if (r < 92)
					mode = MODE_INIT;
				else
					mode = MODE_UNUSED;
				if ($urandom_range(0, 9) == 0)
					ch = 4'($urandom_range(CHANNELS, 15));
				else
					ch = 4'($urandom_range(0, CHANNELS - 1));
				send_item(mode, ch, 1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: mixed hold periods, default pin mapping
		load_settings(64'h0000_0001_0002_0000, 64'h0, 64'hFFFF_0000_0000_0003,
			64'hFFF, 64'h0, 64'hFFF);
		send_item(MODE_INIT, 4'd0, 1'b1);
		send_item(MODE_INIT, 4'd11, 1'b1);
		send_item(MODE_LEVEL, 4'd1, 1'b1);
		send_item(MODE_LEVEL, 4'd2, 1'b1);
		send_item(MODE_LEVEL, 4'd8, 1'b1);
		// out-of-range channels and the unused mode are ignored
		send_item(MODE_LEVEL, 4'd15, 1'b1);
		send_item(MODE_INIT, 4'd12, 1'b0);
		send_item(MODE_UNUSED, 4'd3, 1'b1);
		send_item(MODE_TICK, 4'd0, 1'b0);
		send_item(MODE_TICK, 4'd15, 1'b1);
		// sample returns to committed before the hold expires
		send_item(MODE_LEVEL, 4'd1, 1'b0);
		send_item(MODE_TICK, 4'd7, 1'b0);
		send_item(MODE_TICK, 4'd8, 1'b1);
		// several commits in one tick
		send_item(MODE_LEVEL, 4'd3, 1'b1);
		send_item(MODE_LEVEL, 4'd4, 1'b1);
		send_item(MODE_LEVEL, 4'd7, 1'b1);
		send_item(MODE_TICK, 4'd11, 1'b1);
		send_item(MODE_LEVEL, 4'd0, 1'b0);
		send_item(MODE_LEVEL, 4'd2, 1'b0);
		send_item(MODE_INIT, 4'd5, 1'b0);
		send_item(MODE_TICK, 4'd0, 1'b0);
		send_item(MODE_UNUSED, 4'd0, 1'b0);
		send_item(MODE_TICK, 4'd15, 1'b0);
		wait_idle();

		// random phases over several register settings
		load_settings(periods_upto(3), periods_upto(3), periods_upto(3),
			{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
		run_phase(80);
		wait_idle();
		load_settings(64'h0, 64'h0, 64'h0, '1, 64'h0, 64'h0);
		run_phase(80);
		wait_idle();
		load_settings('1, '1, '1, 64'h0, 64'hFFF, 64'hFFF);
		run_phase(40);
		wait_idle();
		load_settings(periods_upto(7), periods_upto(7), periods_upto(7),
			{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
		run_phase(80);
		wait_idle();
		load_settings(periods_upto(1), periods_upto(1), periods_upto(1),
			{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
		run_phase(80);
		wait_idle();
		load_settings(periods_upto(3), periods_upto(3), periods_upto(3),
			{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
		run_phase(80);
		wait_idle();

		$display("covered %0d input transactions and %0d report transactions", items_sent,
			reports_checked);
		$display("over %0d register settings, zero and all-ones hold periods included",
			settings_used);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
sv/mcid_pkg.sv
sv/mcid_regs.sv
sv/mcid_ctrl.sv
sv/mcid_dp.sv
sv/multi_channel_input_debouncer.sv
tb/debounce_checker.sv
tb/tb.sv
